// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the page allocator.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rpa_pkg.sv -----
// Types and constants of the reference-counted page allocator.
// No dependencies; imported by rpa_ram, the top level and the checker.
package rpa_pkg;

   // request operation codes (req_tuser)
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INC   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // result status codes (rsp_tuser[3:1])
   typedef enum logic [2:0] {
      STAT_OK   = 3'd0,
      STAT_OOM  = 3'd1,
      STAT_BAD  = 3'd2,
      STAT_SAT  = 3'd3,
      STAT_FULL = 3'd4
   } status_type;

   // control sequencer
   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   // register indexes on the csr port
   localparam logic REG_FIRST_PAGE = 1'b0;
   localparam logic REG_END_PAGE   = 1'b1;

   // field widths
   localparam int FIRST_W = 20;
   localparam int END_W   = 21;
   localparam int PAGE_W  = 21;
   localparam int ADDR_W  = 32;
   localparam int REFV_W  = 16;
   localparam int FREE_W  = 17;

   // register reset values
   localparam logic [FIRST_W-1:0] FIRST_RST = 20'd524288;
   localparam logic [END_W-1:0]   END_RST   = 21'd557056;

endpackage

// ----- rtl/rpa_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Uses rpa_pkg; instantiated once for the free stack and once for the reference counts.
module rpa_ram
   import rpa_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/refcounted_page_allocator.sv -----
// Reference-counted page allocator: free stack and count store in synchronous RAM.
// RAM read issued at accept; count written back and result registered in the execute state.
// A new request is accepted only after the last one has executed; a stalled result holds input.
// Reset: synchronous; clears control state, then a clearing pass writes every count
// entry to zero, during which no request is accepted.
// Uses rpa_pkg and rpa_ram.
module refcounted_page_allocator
   import rpa_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_SHIFT = 12,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] page_address, [47:32] ref_value,
                                    // [64:48] free_pages, [71:65] zero
   output logic [3:0]  rsp_tuser,   // [0] released, [3:1] status
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_wdata
);

   localparam int AW      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
   localparam int FW      = $clog2(2 * NUM_PAGES + 1);
   localparam logic [ADDR_W-1:0]     OFS_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;
   localparam logic [ADDR_W-1:0]     NP32     = 32'(NUM_PAGES);
   localparam logic [21:0]           NP22     = 22'(NUM_PAGES);
   localparam logic [DEPTH_W-1:0]    NPD      = DEPTH_W'(NUM_PAGES);
   localparam logic [AW-1:0]         LAST_IDX = AW'(NUM_PAGES - 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

   // control and configuration state
   fsm_type             state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [FIRST_W-1:0]  first_ff, first_in;
   logic [END_W-1:0]    end_ff, end_in;
   logic [PAGE_W-1:0]   top_ff, top_in;
   logic [DEPTH_W-1:0]  ucnt_ff, ucnt_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [FW-1:0]       free_ff, free_in;

   // request held between accept and execute
   op_type              op_ff, op_in;
   logic                bad_ff, bad_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [AW-1:0]       idx_ff, idx_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [REFV_W-1:0]   rsp_ref_ff, rsp_ref_in;
   logic                rsp_rel_ff, rsp_rel_in;
   status_type          rsp_stat_ff, rsp_stat_in;
   logic [FREE_W-1:0]   rsp_free_ff, rsp_free_in;

   // handshake strobes
   logic accept, fire, reload;

   // RAM ports
   logic                  cnt_we, cnt_re, stk_we, stk_re;
   logic [AW-1:0]         cnt_waddr, cnt_raddr, stk_waddr, stk_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
   logic [PAGE_W-1:0]     stk_rd;

   // request decode
   logic [ADDR_W-1:0] req_page, req_diff;
   logic              req_bad;

   // reload values
   logic [21:0]        rl_lim, rl_span;
   logic [PAGE_W-1:0]  rl_top;
   logic [DEPTH_W-1:0] rl_ucnt;

   // execute datapath
   logic [21:0]           sdiff;
   logic                  s_inwin;
   logic [DEPTH_W-1:0]    depth_m1, ucnt_m1;
   logic [PAGE_W-1:0]     apage;
   logic [63:0]           pa_wide;
   logic [COUNT_BITS-1:0] cnew;
   logic [COUNT_BITS+REFV_W-1:0] ref_wide;
   logic [FW+FREE_W-1:0]  free_wide;

   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == FSM_IDLE);
   assign depth_m1   = depth_ff - DEPTH_W'(1);
   assign ucnt_m1    = ucnt_ff - DEPTH_W'(1);

   // memories
   rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES), .AW(AW)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rd)
   );

   rpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES), .AW(AW)) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (page_ff),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   // address check on the incoming request
   always_comb begin
      req_page = req_tdata >> PAGE_SHIFT;
      req_diff = req_page - {12'b0, first_ff};
      req_bad  = ((req_tdata & OFS_MASK) != '0) || (req_page < {12'b0, first_ff}) ||
                 (req_page >= {11'b0, end_ff}) || (req_diff >= NP32);
   end

   // RAM reads issued at accept
   always_comb begin
      cnt_re    = accept && !req_bad && (op_type'(req_tuser) != OP_ALLOC);
      cnt_raddr = req_diff[AW-1:0];
      stk_re    = accept && (op_type'(req_tuser) == OP_ALLOC) && (depth_ff != '0);
      stk_raddr = depth_m1[AW-1:0];
   end

   // configuration registers and the reload of the untouched range
   always_comb begin
      first_in = first_ff;
      end_in   = end_ff;
      reload   = 1'b0;
      if (reset) begin
         first_in = FIRST_RST;
         end_in   = END_RST;
         reload   = 1'b1;
      end else if (csr_we) begin
         reload = 1'b1;
         unique case (csr_index)
            REG_FIRST_PAGE: first_in = csr_wdata[FIRST_W-1:0];
            REG_END_PAGE:   end_in   = csr_wdata[END_W-1:0];
            default:        reload   = 1'b1;
         endcase
      end
      rl_lim  = {2'b0, first_in} + NP22;
      rl_span = {1'b0, end_in} - {2'b0, first_in};
      rl_top  = ({1'b0, end_in} < rl_lim) ? end_in : rl_lim[PAGE_W-1:0];
      if (end_in <= {1'b0, first_in}) begin
         rl_ucnt = '0;
      end else if (rl_span >= NP22) begin
         rl_ucnt = NPD;
      end else begin
         rl_ucnt = rl_span[DEPTH_W-1:0];
      end
   end

   // sequencer: clearing pass, idle, execute
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (fire) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_CLEAR;
      endcase
   end

   // execute: modify the count, push or pop the stack, build the result
   always_comb begin
      op_in      = accept ? op_type'(req_tuser) : op_ff;
      bad_in     = accept ? req_bad : bad_ff;
      page_in    = accept ? req_page[PAGE_W-1:0] : page_ff;
      idx_in     = accept ? req_diff[AW-1:0] : idx_ff;

      top_in     = top_ff;
      ucnt_in    = ucnt_ff;
      depth_in   = depth_ff;
      free_in    = free_ff;
      cnt_we     = (state_ff == FSM_CLEAR);
      cnt_waddr  = (state_ff == FSM_CLEAR) ? clr_ff : idx_ff;
      cnt_wdata  = '0;
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[AW-1:0];
      apage      = '0;
      cnew       = cnt_rd;
      rsp_page_in = '0;
      rsp_rel_in  = 1'b0;
      rsp_stat_in = STAT_OK;

      sdiff   = {1'b0, stk_rd} - {2'b0, first_ff};
      s_inwin = (stk_rd >= {1'b0, first_ff}) && (sdiff < NP22);

      if (fire) begin
         if (op_ff == OP_ALLOC) begin
            cnew = CNT_ONE;
            if (depth_ff != '0) begin
               apage     = stk_rd;
               depth_in  = depth_m1;
               free_in   = free_ff - FW'(1);
               cnt_we    = s_inwin;
               cnt_waddr = sdiff[AW-1:0];
            end else if (ucnt_ff != '0) begin
               apage     = top_ff - PAGE_W'(1);
               top_in    = apage;
               ucnt_in   = ucnt_m1;
               free_in   = free_ff - FW'(1);
               cnt_we    = 1'b1;
               cnt_waddr = ucnt_m1[AW-1:0];
            end else begin
               cnew        = '0;
               rsp_stat_in = STAT_OOM;
            end
            cnt_wdata   = CNT_ONE;
            pa_wide     = 64'(apage) << PAGE_SHIFT;
            rsp_page_in = pa_wide[ADDR_W-1:0];
         end else if (bad_ff) begin
            cnew        = '0;
            rsp_stat_in = STAT_BAD;
         end else begin
            case (op_ff)
               OP_FREE: begin
                  if (cnt_rd > CNT_ONE) begin
                     cnew = cnt_rd - CNT_ONE;
                  end else begin
                     cnew = '0;
                     if (depth_ff < NPD) begin
                        stk_we     = 1'b1;
                        depth_in   = depth_ff + DEPTH_W'(1);
                        free_in    = free_ff + FW'(1);
                        rsp_rel_in = 1'b1;
                     end else begin
                        rsp_stat_in = STAT_FULL;
                     end
                  end
               end
               OP_INC: begin
                  if (cnt_rd == CNT_MAX) begin
                     rsp_stat_in = STAT_SAT;
                  end else begin
                     cnew = cnt_rd + CNT_ONE;
                  end
               end
               default: cnew = cnt_rd;
            endcase
            cnt_we    = 1'b1;
            cnt_wdata = cnew;
         end
      end

      pa_wide = 64'(apage) << PAGE_SHIFT;

      // a configuration write or reset restarts the untouched range and empties the stack
      if (reload) begin
         top_in   = rl_top;
         ucnt_in  = rl_ucnt;
         depth_in = '0;
         free_in  = FW'(rl_ucnt);
      end

      ref_wide   = {{REFV_W{1'b0}}, cnew};
      rsp_ref_in = ref_wide[REFV_W-1:0];
      free_wide  = {{FREE_W{1'b0}}, free_in};
      rsp_free_in = free_wide[FREE_W-1:0];

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration and allocator state (reset values come through the reload)
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      end_ff   <= end_in;
      top_ff   <= top_in;
      ucnt_ff  <= ucnt_in;
      depth_ff <= depth_in;
      free_ff  <= free_in;
   end

   // request and result payload
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      bad_ff  <= bad_in;
      page_ff <= page_in;
      idx_ff  <= idx_in;
      if (fire) begin
         rsp_page_ff <= rsp_page_in;
         rsp_ref_ff  <= rsp_ref_in;
         rsp_rel_ff  <= rsp_rel_in;
         rsp_stat_ff <= rsp_stat_in;
         rsp_free_ff <= rsp_free_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_free_ff, rsp_ref_ff, rsp_page_ff};
   assign rsp_tuser  = {rsp_stat_ff, rsp_rel_ff};

endmodule

// ----- rtl/rpa_checker.sv -----
// Port-level checks of the page allocator, bound to the top level.
// Uses rpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpa_checker
   import rpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // a stalled result holds its payload
   `RPA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // one request at a time: no accept in the cycle after an accept
   `RPA_ASSERT_NXT(a_req_gap, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted back to back")

   // status code stays within its defined codes
   `RPA_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid, rsp_tuser[3:1] <= STAT_FULL, "undefined status code")

   // a released page only comes with an ok status
   `RPA_ASSERT_IMP(a_released_ok, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tuser[3:1] == STAT_OK, "release with error status")

   // out of memory means no page, no count and an empty pool
   `RPA_ASSERT_IMP(a_oom_empty, clock, reset, rsp_tvalid && (rsp_tuser[3:1] == STAT_OOM), rsp_tdata[64:0] == 65'd0, "out of memory with data")

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);
